FILE: rtl/lvbs_pkg.sv
// Shared definitions for the longest valid bracket span block.
// Holds the open-bracket code, the result width and the result struct.
// No dependencies.
package lvbs_pkg;

  localparam logic [7:0] OPEN_CHAR = 8'd40;
  localparam int unsigned LONGEST_W = 11;

  typedef struct packed {
    logic [LONGEST_W-1:0] longest;
    logic                 overflow;
  } result_t;

endpackage

FILE: rtl/lvbs_stack_ram.sv
// Single-port-write, single-port-read synchronous RAM for the index stack.
// Read data is registered. Depends on nothing.
module lvbs_stack_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/lvbs_ctrl.sv
// Stack control for the longest valid bracket span block.
// Keeps top and next-below in registers, the base entry in a register and
// the rest in the stack RAM. Depends on lvbs_pkg.
module lvbs_ctrl #(
  parameter int unsigned MAX_LEN = 1024,
  localparam int unsigned PW     = $clog2(MAX_LEN + 1),
  localparam int unsigned CW     = $clog2(MAX_LEN + 2),
  localparam int unsigned AW     = $clog2(MAX_LEN)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        symbol_i,
  input  logic              last_i,
  input  logic [PW-1:0]     rd_data_i,
  output logic              we_o,
  output logic [AW-1:0]     waddr_o,
  output logic [PW-1:0]     wdata_o,
  output logic [AW-1:0]     raddr_o,
  output lvbs_pkg::result_t result_o
);
  import lvbs_pkg::*;

  localparam int unsigned DEPTH = MAX_LEN + 1;
  localparam int unsigned WIDE  = (PW > LONGEST_W) ? PW : LONGEST_W;

  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] top_q, top_d;
  logic [PW-1:0] below_q, below_d;
  logic [PW-1:0] base_q, base_d;
  logic [PW-1:0] best_q, best_d;
  logic          ovf_q, ovf_d;
  logic          rd_base_q, rd_base_d;

  logic [PW-1:0]   here;
  logic [PW-1:0]   span;
  logic [PW-1:0]   refill;
  logic [CW-1:0]   popped;
  logic            full;
  logic [WIDE-1:0] best_ext;

  always_comb begin
    here     = pos_q + PW'(1);
    span     = here - below_q;
    full     = (pos_q >= PW'(MAX_LEN));
    popped   = (count_q != '0) ? (count_q - CW'(1)) : '0;
    // The entry that slides under the new top on a pop was read last cycle.
    refill   = rd_base_q ? base_q : rd_data_i;

    count_d  = count_q;
    pos_d    = pos_q;
    top_d    = top_q;
    below_d  = below_q;
    base_d   = base_q;
    best_d   = best_q;
    ovf_d    = ovf_q;
    we_o     = 1'b0;
    waddr_o  = AW'(count_q - CW'(1));
    wdata_o  = here;

    if (accept_i) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = here;
        if (symbol_i == OPEN_CHAR) begin
          if (count_q < CW'(DEPTH)) begin
            count_d = count_q + CW'(1);
            top_d   = here;
            below_d = top_q;
            if (count_q == '0) begin
              base_d = here;
            end else begin
              we_o = 1'b1;
            end
          end
        end else if (popped == '0) begin
          // A stray close becomes the new base.
          count_d = CW'(1);
          top_d   = here;
          base_d  = here;
        end else begin
          count_d = popped;
          top_d   = below_q;
          below_d = refill;
          if ((here >= below_q) && (span > best_q)) begin
            best_d = span;
          end
        end
      end
    end

    best_ext          = WIDE'(best_d);
    result_o.longest  = best_ext[LONGEST_W-1:0];
    result_o.overflow = ovf_d;

    if (accept_i && last_i) begin
      count_d = CW'(1);
      pos_d   = '0;
      top_d   = '0;
      base_d  = '0;
      best_d  = '0;
      ovf_d   = 1'b0;
    end

    // Prefetch the entry two below the next top; writes only land at or
    // above the new top, so a read address in use never collides with a write.
    rd_base_d = (32'(count_d) == 32'd3);
    raddr_o   = (32'(count_d) >= 32'd4) ? AW'(32'(count_d) - 32'd4) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CW'(1);
      pos_q     <= '0;
      top_q     <= '0;
      below_q   <= '0;
      base_q    <= '0;
      best_q    <= '0;
      ovf_q     <= 1'b0;
      rd_base_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      pos_q     <= pos_d;
      top_q     <= top_d;
      below_q   <= below_d;
      base_q    <= base_d;
      best_q    <= best_d;
      ovf_q     <= ovf_d;
      rd_base_q <= rd_base_d;
    end
  end

endmodule

FILE: rtl/longest_valid_bracket_span_top.sv
// Top level of the longest valid bracket span block.
// Instantiates lvbs_ctrl and lvbs_stack_ram and holds the result register.
// Depends on lvbs_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------
//   in      | input     | in_valid_i / in_stall_o | symbol_i, last_i
//   out     | output    | out_valid_o/out_stall_i | longest_o, overflow_o
//
// Each character beat yields exactly one result beat, in the cycle after it
// is accepted. A new beat is taken every cycle unless the input stalls:
// the stack's top two entries sit in registers and the RAM read for a pop
// is issued in the cycle before, so the single RAM write port and read port
// bound the rate at one per cycle. Reset puts the stack back to its lone base
// entry at once; the RAM itself is never cleared, since only written entries
// are ever read. The input stalls only while a result waits in the output
// register and the output side stalls too.
module longest_valid_bracket_span_top #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         symbol_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lvbs_pkg::LONGEST_W-1:0]     longest_o,
  output logic                               overflow_o
);
  import lvbs_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);

  logic          accept;
  logic          we;
  logic [AW-1:0] waddr;
  logic [PW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [PW-1:0] rdata;
  result_t       step_res;

  logic    out_valid_q, out_valid_d;
  result_t res_q;

  // The output register frees up in the same cycle its beat is taken.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  lvbs_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .symbol_i  (symbol_i),
    .last_i    (last_i),
    .rd_data_i (rdata),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .raddr_o   (raddr),
    .result_o  (step_res)
  );

  lvbs_stack_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The payload holds while stalled, since accept is low then.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign longest_o   = res_q.longest;
  assign overflow_o  = res_q.overflow;

endmodule

FILE: rtl/lvbs_checker.sv
// Port-level checks for longest_valid_bracket_span_top, attached by bind.
// Depends on lvbs_pkg for the result width.
module lvbs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [lvbs_pkg::LONGEST_W-1:0] longest_o,
  input logic                           overflow_o
);

  // Every accepted character produces a result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("no result after an accepted character");

  // The input only stalls while a result is held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  // A well-formed span always has even length.
  a_even_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !longest_o[0])
    else $error("odd longest span reported");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(longest_o) && $stable(overflow_o)))
    else $error("stalled result beat changed");

endmodule

bind longest_valid_bracket_span_top lvbs_checker u_lvbs_checker (.*);
